/* rtl/core/mwmm_pkg.sv */
// Shared constants and types of the masked window mean and median core.
package mwmm_pkg;

   localparam int HALF_MAX_DEF   = 50;
   localparam int LEVEL_BITS_DEF = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 6;
   localparam int HALF_WIN_BITS  = 6;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HALF_WINDOW  = 2'd0,
      CSR_AVERAGE_MODE = 2'd1
   } csr_index_type;

endpackage

/* rtl/core/mwmm_if.sv */
// Channel interfaces of the masked window mean and median core.
interface mwmm_req_if #(parameter int LEVEL_BITS = mwmm_pkg::LEVEL_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [LEVEL_BITS-1:0] level;
   logic                         has_level;
   logic                         last_of_track;
   modport source (output valid, level, has_level, last_of_track, input ready);
   modport sink   (input valid, level, has_level, last_of_track, output ready);
endinterface

interface mwmm_rsp_if #(parameter int LEVEL_BITS = mwmm_pkg::LEVEL_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [LEVEL_BITS-1:0] avg_level;
   logic                         point_valid;
   logic                         last_point;
   modport source (output valid, avg_level, point_valid, last_point, input ready);
   modport sink   (input valid, avg_level, point_valid, last_point, output ready);
endinterface

interface mwmm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mwmm_pkg::CSR_IDX_BITS-1:0]    index;
   logic [mwmm_pkg::CSR_DATA_BITS-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/masked_window_mean_median_core.sv */
// Top level of the masked window mean and median core.
// An item is taken; then per emitted point a window of W samples is gathered, and either
// LEVEL_BITS+CW+1 divider steps (mean) or LEVEL_BITS radix passes over the U present samples
// (median) form the word that is handed over. The core works on one item at a time, busy in the
// gather pass, the divider and the radix select passes. Synchronous active-high reset clears the
// state, settings, ring pointers, track count and output valid, not the datapath registers; the
// sample ring needs no clearing since only written entries are read.
module masked_window_mean_median_core #(
   parameter int HALF_MAX   = mwmm_pkg::HALF_MAX_DEF,
   parameter int LEVEL_BITS = mwmm_pkg::LEVEL_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   mwmm_req_if.sink    req_ch,
   mwmm_rsp_if.source  rsp_ch,
   mwmm_csr_if.sink    csr_ch
);
   import mwmm_pkg::*;

   // Ring depth, index width and count width (counts may equal the depth).
   localparam int D    = 2 * HALF_MAX;
   localparam int AW   = (D > 1) ? $clog2(D) : 1;
   localparam int CW   = $clog2(D + 1);
   localparam int HCW  = $clog2(HALF_MAX + 1);
   localparam int SW   = LEVEL_BITS + CW + 1;
   localparam int MW   = SW;
   localparam int SCW  = $clog2(MW + 1);
   localparam int RW   = LEVEL_BITS + 2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_GATHER, ST_ROUTE, ST_DIV, ST_SELECT, ST_PASS_END, ST_EMIT
   } state_type;

   // Memories: the sample ring and the gathered present values of one window.
   logic [LEVEL_BITS:0]   ring_mem [D];
   logic [LEVEL_BITS-1:0] vals_mem [D];
   logic [LEVEL_BITS:0]   ring_q_ff;
   logic [LEVEL_BITS-1:0] vals_q_ff;

   state_type state_ff, state_in;
   logic [HALF_WIN_BITS-1:0] half_window_ff, half_window_in;
   logic average_mode_ff, average_mode_in;
   logic [AW-1:0] write_slot_ff, write_slot_in, emit_index_ff, emit_index_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] track_count_ff, track_count_in;
   logic last_ff, last_in;
   logic [HCW-1:0] h_ff, h_in, emit_cnt_ff, emit_cnt_in;
   logic [CW-1:0] earlier_ff, earlier_in, total_ff, total_in;
   logic [CW-1:0] iss_ff, iss_in, prc_ff, prc_in, used_ff, used_in;
   logic rd_vld_ff, rd_vld_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic own_ff, own_in, fin_last_ff, fin_last_in;
   logic [MW-1:0] quo_ff, quo_in;
   logic [CW:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [SCW-1:0] step_ff, step_in;
   logic [LEVEL_BITS-1:0] bsel_ff, bsel_in, mask_ff, mask_in;
   logic [LEVEL_BITS-1:0] pfx1_ff, pfx1_in, pfx2_ff, pfx2_in;
   logic [CW-1:0] k1_ff, k1_in, k2_ff, k2_in, c1_ff, c1_in, c2_ff, c2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic rsp_pv_ff, rsp_pv_in, rsp_last_ff, rsp_last_in;

   // Window bookkeeping, worked out from the pointers in the check state.
   logic [CW-1:0] ws_w, ei_w, pend, need, prior_w, h_w, earlier_w, later_w, span_w;
   logic [CW-1:0] start_w;
   logic stop_w;
   logic req_acc;
   logic [CW:0] div_shift;
   logic [LEVEL_BITS-1:0] sbit, u_val;
   logic [LEVEL_BITS-1:0] pfx1_fin, pfx2_fin;
   logic signed [RW-1:0] med_sum, med_neg, med_res;
   logic [MW-1:0] abs_sum;

   assign req_acc       = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.avg_level   = rsp_level_ff;
   assign rsp_ch.point_valid = rsp_pv_ff;
   assign rsp_ch.last_point  = rsp_last_ff;

   assign sbit  = {1'b1, {(LEVEL_BITS-1){1'b0}}};
   assign u_val = vals_q_ff ^ sbit;

   always_comb begin
      ws_w  = CW'(write_slot_ff);
      ei_w  = CW'(emit_index_ff);
      h_w   = CW'(h_ff);
      pend  = (ws_w >= ei_w) ? ws_w - ei_w : ws_w + CW'(D) - ei_w;
      need  = (h_ff != '0) ? h_w : CW'(1);
      stop_w = (emit_cnt_ff == HCW'(HALF_MAX)) || (pend == '0) || (!last_ff && pend < need);
      prior_w = (track_count_ff >= pend) ? track_count_ff - pend : '0;
      if (h_ff == '0) begin
         earlier_w = '0;
         later_w   = '0;
      end else begin
         earlier_w = (prior_w < h_w) ? prior_w : h_w;
         later_w   = ((pend - 1'b1) < (h_w - 1'b1)) ? pend - 1'b1 : h_w - 1'b1;
      end
      span_w  = ((CW+1)'(earlier_w) + (CW+1)'(later_w) + 1'b1 > (CW+1)'(D))
                ? CW'(D) : CW'(earlier_w + later_w + 1'b1);
      start_w = (ei_w >= earlier_w) ? ei_w - earlier_w : ei_w + CW'(D) - earlier_w;
   end

   // The shared divider takes one quotient bit a step.
   assign div_shift = {rem_ff[CW-1:0], quo_ff[MW-1]};
   assign abs_sum   = sum_ff[SW-1] ? MW'(-sum_ff) : MW'(sum_ff);

   // Median: mean of the two middle values, rounded half away from zero. An odd count selects
   // the same value twice. The last pass decides the lowest prefix bit here as well.
   always_comb begin
      pfx1_fin = (k1_ff >= c1_ff) ? (pfx1_ff | bsel_ff) : pfx1_ff;
      pfx2_fin = (k2_ff >= c2_ff) ? (pfx2_ff | bsel_ff) : pfx2_ff;
      med_sum = RW'(signed'(pfx1_fin ^ sbit)) + RW'(signed'(pfx2_fin ^ sbit));
      med_neg = -med_sum;
      if (med_sum >= 0) begin
         med_res = (med_sum + RW'(1)) >>> 1;
      end else begin
         med_res = -((med_neg + RW'(1)) >>> 1);
      end
   end

   always_comb begin
      state_in = state_ff;
      half_window_in = half_window_ff;
      average_mode_in = average_mode_ff;
      write_slot_in = write_slot_ff;
      emit_index_in = emit_index_ff;
      rd_ptr_in = rd_ptr_ff;
      track_count_in = track_count_ff;
      last_in = last_ff;
      h_in = h_ff;
      emit_cnt_in = emit_cnt_ff;
      earlier_in = earlier_ff;
      total_in = total_ff;
      iss_in = iss_ff;
      prc_in = prc_ff;
      used_in = used_ff;
      rd_vld_in = 1'b0;
      sum_in = sum_ff;
      own_in = own_ff;
      fin_last_in = fin_last_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      bsel_in = bsel_ff;
      mask_in = mask_ff;
      pfx1_in = pfx1_ff;
      pfx2_in = pfx2_ff;
      k1_in = k1_ff;
      k2_in = k2_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_pv_in = rsp_pv_ff;
      rsp_last_in = rsp_last_ff;

      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_HALF_WINDOW) begin
            half_window_in = HALF_WIN_BITS'(csr_ch.data);
         end else if (csr_ch.index == CSR_AVERAGE_MODE) begin
            average_mode_in = csr_ch.data[0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               write_slot_in = (write_slot_ff == AW'(D - 1)) ? '0 : write_slot_ff + 1'b1;
               if (track_count_ff < CW'(D)) begin
                  track_count_in = track_count_ff + 1'b1;
               end
               last_in = req_ch.last_of_track;
               h_in = (int'(half_window_ff) > HALF_MAX) ? HCW'(HALF_MAX) : HCW'(half_window_ff);
               emit_cnt_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stop_w) begin
               if (last_ff) begin
                  track_count_in = '0;
               end
               state_in = ST_IDLE;
            end else begin
               earlier_in = earlier_w;
               total_in = span_w;
               rd_ptr_in = AW'(start_w);
               fin_last_in = last_ff && (pend == CW'(1));
               iss_in = '0;
               prc_in = '0;
               used_in = '0;
               sum_in = '0;
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            if (iss_ff < total_ff) begin
               rd_vld_in = 1'b1;
               iss_in = iss_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == AW'(D - 1)) ? '0 : rd_ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (ring_q_ff[LEVEL_BITS]) begin
                  sum_in = sum_ff + SW'(signed'(ring_q_ff[LEVEL_BITS-1:0]));
                  used_in = used_ff + 1'b1;
               end
               if (prc_ff == earlier_ff) begin
                  own_in = ring_q_ff[LEVEL_BITS];
               end
               prc_in = prc_ff + 1'b1;
               if (prc_ff + 1'b1 == total_ff) begin
                  state_in = ST_ROUTE;
               end
            end
         end
         ST_ROUTE: begin
            if (used_ff == '0) begin
               rsp_level_in = '0;
               rsp_pv_in = own_ff;
               rsp_last_in = fin_last_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_EMIT;
            end else if (!average_mode_ff) begin
               neg_in = sum_ff[SW-1];
               quo_in = abs_sum + MW'(used_ff >> 1);
               rem_in = '0;
               step_in = SCW'(MW);
               state_in = ST_DIV;
            end else begin
               k1_in = (used_ff - 1'b1) >> 1;
               k2_in = used_ff >> 1;
               pfx1_in = '0;
               pfx2_in = '0;
               mask_in = '0;
               bsel_in = sbit;
               c1_in = '0;
               c2_in = '0;
               iss_in = '0;
               prc_in = '0;
               state_in = ST_SELECT;
            end
         end
         ST_DIV: begin
            if (div_shift >= {1'b0, used_ff}) begin
               rem_in = div_shift - {1'b0, used_ff};
               quo_in = {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = div_shift;
               quo_in = {quo_ff[MW-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == SCW'(1)) begin
               rsp_level_in = neg_ff ? -LEVEL_BITS'(quo_in) : LEVEL_BITS'(quo_in);
               rsp_pv_in = own_ff;
               rsp_last_in = fin_last_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_SELECT: begin
            // One radix pass: count values that share the chosen upper bits and have a
            // zero at the current bit, for both middle ranks at once.
            if (iss_ff < used_ff) begin
               rd_vld_in = 1'b1;
               iss_in = iss_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if ((((u_val ^ pfx1_ff) & mask_ff) == '0) && ((u_val & bsel_ff) == '0)) begin
                  c1_in = c1_ff + 1'b1;
               end
               if ((((u_val ^ pfx2_ff) & mask_ff) == '0) && ((u_val & bsel_ff) == '0)) begin
                  c2_in = c2_ff + 1'b1;
               end
               prc_in = prc_ff + 1'b1;
               if (prc_ff + 1'b1 == used_ff) begin
                  state_in = ST_PASS_END;
               end
            end
         end
         ST_PASS_END: begin
            if (k1_ff >= c1_ff) begin
               pfx1_in = pfx1_ff | bsel_ff;
               k1_in = k1_ff - c1_ff;
            end
            if (k2_ff >= c2_ff) begin
               pfx2_in = pfx2_ff | bsel_ff;
               k2_in = k2_ff - c2_ff;
            end
            mask_in = mask_ff | bsel_ff;
            bsel_in = bsel_ff >> 1;
            c1_in = '0;
            c2_in = '0;
            iss_in = '0;
            prc_in = '0;
            if (bsel_ff[0]) begin
               state_in = ST_EMIT;
               rsp_valid_in = 1'b1;
               rsp_pv_in = own_ff;
               rsp_last_in = fin_last_ff;
            end else begin
               state_in = ST_SELECT;
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               emit_index_in = (emit_index_ff == AW'(D - 1)) ? '0 : emit_index_ff + 1'b1;
               emit_cnt_in = emit_cnt_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The median result is final once the last pass has fixed both prefixes.
      if (state_ff == ST_PASS_END && bsel_ff[0]) begin
         rsp_level_in = LEVEL_BITS'(med_res);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         half_window_ff  <= '0;
         average_mode_ff <= 1'b0;
         write_slot_ff   <= '0;
         emit_index_ff   <= '0;
         track_count_ff  <= '0;
         last_ff         <= 1'b0;
         emit_cnt_ff     <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         half_window_ff  <= half_window_in;
         average_mode_ff <= average_mode_in;
         write_slot_ff   <= write_slot_in;
         emit_index_ff   <= emit_index_in;
         track_count_ff  <= track_count_in;
         last_ff         <= last_in;
         emit_cnt_ff     <= emit_cnt_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      h_ff         <= h_in;
      rd_ptr_ff    <= rd_ptr_in;
      earlier_ff   <= earlier_in;
      total_ff     <= total_in;
      iss_ff       <= iss_in;
      prc_ff       <= prc_in;
      used_ff      <= used_in;
      sum_ff       <= sum_in;
      own_ff       <= own_in;
      fin_last_ff  <= fin_last_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      bsel_ff      <= bsel_in;
      mask_ff      <= mask_in;
      pfx1_ff      <= pfx1_in;
      pfx2_ff      <= pfx2_in;
      k1_ff        <= k1_in;
      k2_ff        <= k2_in;
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      rsp_level_ff <= rsp_level_in;
      rsp_pv_ff    <= rsp_pv_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         ring_mem[write_slot_ff] <= {req_ch.has_level, req_ch.level};
      end
      ring_q_ff <= ring_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_GATHER && rd_vld_ff && ring_q_ff[LEVEL_BITS]) begin
         vals_mem[used_ff[AW-1:0]] <= ring_q_ff[LEVEL_BITS-1:0];
      end
      vals_q_ff <= vals_mem[iss_ff[AW-1:0]];
   end

endmodule

/* rtl/core/mwmm_checker.sv */
// Port-level checker of the masked window mean and median core, with its bind.
module mwmm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A word waiting at the output stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // The core works on one item at a time, so it never takes input while a result waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   // Once an item is taken the core is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("core ready right after taking an item");

   // Reset leaves no result word on offer.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind masked_window_mean_median_core mwmm_checker u_mwmm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

/* dv/tb_masked_window_mean_median_core.sv */
`timescale 1ns / 100ps
// Testbench of the masked window mean and median core: scoreboard, drivers and stimulus.
module tb_masked_window_mean_median_core;
   import mwmm_pkg::*;

   localparam int LVL_W      = LEVEL_BITS_DEF;
   localparam int HALF_LIM   = HALF_MAX_DEF;
   localparam int RING_SLOTS = 2 * HALF_MAX_DEF;
   localparam bit MODE_MEAN   = 1'b0;
   localparam bit MODE_MEDIAN = 1'b1;
   // The slowest point is one with the widest median window, and this settle
   // time covers any point still in flight.
   localparam int SETTLE_CYCLES = 4000;
   localparam int LONG_HOLD     = 3000;

   typedef struct packed {
      logic                    present;
      logic signed [LVL_W-1:0] lvl;
   } sample_type;

   typedef struct packed {
      logic signed [LVL_W-1:0] avg_level;
      logic                    point_valid;
      logic                    last_point;
   } point_word_type;

   // The scoreboard keeps its own copy of the track window and predicts the
   // averaged word for every point the core has to emit.
   class level_scoreboard;
      sample_type     ring[RING_SLOTS];
      int unsigned    wr_slot;
      int unsigned    trk_cnt;
      int unsigned    emit_idx;
      int unsigned    half;
      bit             mode;
      point_word_type expected_q[$];
      int             err_cnt;

      function void set_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] d);
         if (idx == CSR_HALF_WINDOW) half = d;
         else if (idx == CSR_AVERAGE_MODE) mode = d[0];
      endfunction

      // Round to nearest, ties away from zero.
      function longint round_div(longint s, longint n);
         if (s >= 0) return (s + n / 2) / n;
         return -((-s + n / 2) / n);
      endfunction

      function longint window_value(int unsigned earlier, int unsigned later);
         longint      vals[RING_SLOTS];
         longint      sum;
         longint      x;
         int unsigned used;
         int unsigned slot;
         int          m;
         sum = 0;
         used = 0;
         for (int unsigned k = 0; k <= earlier + later && k < RING_SLOTS; k++) begin
            slot = (emit_idx + RING_SLOTS - earlier + k) % RING_SLOTS;
            if (ring[slot].present) begin
               vals[used] = ring[slot].lvl;
               sum += vals[used];
               used++;
            end
         end
         if (used == 0) return 0;
         if (mode == MODE_MEAN) return round_div(sum, used);
         for (int k = 1; k < used; k++) begin
            x = vals[k];
            m = k;
            while (m > 0 && vals[m-1] > x) begin
               vals[m] = vals[m-1];
               m--;
            end
            vals[m] = x;
         end
         if (used % 2) return vals[used/2];
         return round_div(vals[used/2-1] + vals[used/2], 2);
      endfunction

      function void note_item(logic signed [LVL_W-1:0] lvl, logic has, logic last);
         int unsigned h, need, pend, prior, earlier, later, cnt;
         point_word_type w;
         h = (half > HALF_LIM) ? HALF_LIM : half;
         need = h ? h : 1;
         cnt = 0;
         ring[wr_slot] = '{present: has, lvl: lvl};
         wr_slot = (wr_slot + 1) % RING_SLOTS;
         if (trk_cnt < RING_SLOTS) trk_cnt++;
         while (cnt < HALF_LIM) begin
            pend = (wr_slot + RING_SLOTS - emit_idx) % RING_SLOTS;
            if (pend == 0) break;
            if (!last && pend < need) break;
            prior = (trk_cnt >= pend) ? trk_cnt - pend : 0;
            earlier = 0;
            later = 0;
            if (h) begin
               earlier = (prior < h) ? prior : h;
               later = (pend - 1 < h - 1) ? pend - 1 : h - 1;
            end
            w.avg_level = LVL_W'(window_value(earlier, later));
            w.point_valid = ring[emit_idx].present;
            w.last_point = last && pend == 1;
            expected_q.push_back(w);
            emit_idx = (emit_idx + 1) % RING_SLOTS;
            cnt++;
         end
         if (last) trk_cnt = 0;
      endfunction

      function void check_result(point_word_type got);
         point_word_type exp_w;
         if (expected_q.size() == 0) begin
            $error("unexpected word: avg_level %0d", got.avg_level);
            err_cnt++;
            return;
         end
         exp_w = expected_q.pop_front();
         if (got.avg_level !== exp_w.avg_level) begin
            $error("avg_level expected %0d actual %0d", exp_w.avg_level, got.avg_level);
            err_cnt++;
         end
         if (got.point_valid !== exp_w.point_valid) begin
            $error("point_valid expected %0b actual %0b", exp_w.point_valid, got.point_valid);
            err_cnt++;
         end
         if (got.last_point !== exp_w.last_point) begin
            $error("last_point expected %0b actual %0b", exp_w.last_point, got.last_point);
            err_cnt++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   long_hold_req;

   mwmm_req_if req_ch();
   mwmm_rsp_if rsp_ch();
   mwmm_csr_if csr_ch();

   level_scoreboard sb = new();

   masked_window_mean_median_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: a random stall before each word, plus one long hold-off on
   // request so the core backs up and stalls its input.
   initial begin
      int n;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            n = $urandom_range(0, 3);
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Every accepted word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result('{avg_level: rsp_ch.avg_level, point_valid: rsp_ch.point_valid,
                           last_point: rsp_ch.last_point});
   end

   // Offers one input word after a random gap; when the gap is zero the valid
   // stays high and only the payload changes on that edge.
   task automatic send_point(logic signed [LVL_W-1:0] lvl, logic has, logic last);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.level         <= lvl;
      req_ch.has_level     <= has;
      req_ch.last_of_track <= last;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(lvl, has, last);
   endtask

   task automatic drop_valid();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Registers are to change only once the core has drained everything it owes; this task does not wait.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_reg(idx, d);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(int unsigned h, bit m);
      wait_drained();
      write_reg(CSR_HALF_WINDOW, CSR_DATA_BITS'(h));
      write_reg(CSR_AVERAGE_MODE, CSR_DATA_BITS'(m));
   endtask

   // Corner points: full scale levels, absent samples, a single point track,
   // an all-absent track, and even-count medians and means that tie at a half.
   task automatic directed_points();
      send_point(16'sh7FFF, 1'b1, 1'b0);
      send_point(16'sh7FFF, 1'b1, 1'b0);
      send_point(16'sh8000, 1'b1, 1'b0);
      send_point(-16'sd32767, 1'b1, 1'b0);
      send_point(16'sd0, 1'b0, 1'b0);
      send_point(16'sd1, 1'b1, 1'b0);
      send_point(16'sd2, 1'b1, 1'b1);
      send_point(16'sd5, 1'b1, 1'b1);
      send_point(16'sd7, 1'b0, 1'b0);
      send_point(-16'sd3, 1'b0, 1'b1);
      send_point(-16'sd1, 1'b1, 1'b0);
      send_point(-16'sd2, 1'b1, 1'b0);
      send_point(-16'sd1, 1'b1, 1'b0);
      send_point(-16'sd2, 1'b1, 1'b1);
      drop_valid();
   endtask

   // Random tracks: mostly short, a few longer than the sample ring so the
   // track length saturates; levels span the full range with some clustering
   // so medians and ties actually occur.
   task automatic random_tracks(int n_points);
      int len, pos;
      logic signed [LVL_W-1:0] lvl;
      logic has;
      len = 0;
      pos = 0;
      for (int i = 0; i < n_points; i++) begin
         if (pos == len) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 110)
                                                : $urandom_range(1, 12);
            pos = 0;
         end
         case ($urandom_range(0, 3))
            0: lvl = LVL_W'($urandom);
            1: lvl = LVL_W'($urandom_range(0, 7) - 4);
            2: lvl = LVL_W'(($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
                            ^ $urandom_range(0, 3));
            default: lvl = LVL_W'($urandom_range(0, 255) - 128);
         endcase
         has = ($urandom_range(0, 4) != 0);
         pos++;
         send_point(lvl, has, pos == len || i == n_points - 1);
      end
      drop_valid();
   endtask

   initial begin
      reset               = 1'b1;
      long_hold_req       = 1'b0;
      req_ch.valid        = 1'b0;
      req_ch.level        = '0;
      req_ch.has_level    = 1'b0;
      req_ch.last_of_track = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_HALF_WINDOW;
      csr_ch.data         = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings first: no averaging at all.
      random_tracks(30);
      set_window(2, MODE_MEDIAN);
      directed_points();
      set_window(2, MODE_MEAN);
      directed_points();
      set_window(1, MODE_MEDIAN);
      random_tracks(40);
      set_window(3, MODE_MEAN);
      long_hold_req = 1'b1;
      random_tracks(60);
      set_window(7, MODE_MEDIAN);
      random_tracks(60);
      set_window(4, MODE_MEAN);
      random_tracks(60);
      set_window(63, MODE_MEDIAN);
      random_tracks(30);
      set_window(50, MODE_MEAN);
      random_tracks(30);
      set_window(0, MODE_MEDIAN);
      random_tracks(40);
      set_window(5, MODE_MEDIAN);
      random_tracks(50);

      wait_drained();
      if (sb.err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
